// ===== rtl/fpau_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fpau_pkg
// Shared types, opcodes and binary32 unpack / round / pack helpers.
// ---------------------------------------------------------------------------
package fpau_pkg;

	localparam int Q_W = 10;
	localparam int RQ_W = 12;

	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
	localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
	localparam logic signed [Q_W-1:0] Q_DENORM = -10'sd149;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_MUL = 2'd1,
		OP_CMP = 2'd2,
		OP_NEG = 2'd3
	} fpau_op_t;

	typedef enum logic [1:0] {
		KIND_ZERO = 2'd0,
		KIND_FIN  = 2'd1,
		KIND_INF  = 2'd2,
		KIND_NAN  = 2'd3
	} fpau_kind_t;

	// value = mant * 2^q, mant in [2^23, 2^24) for finite values
	typedef struct packed {
		fpau_kind_t            kind;
		logic                  sg;
		logic [23:0]           mant;
		logic signed [Q_W-1:0] q;
	} fpau_val_t;

	function automatic fpau_val_t fpau_unpack(input logic [31:0] u);
		fpau_val_t r;
		logic [7:0] e;
		logic [22:0] m;
		logic [4:0] lz;
		e = u[30:23];
		m = u[22:0];
		r.sg = u[31];
		r.mant = '0;
		r.q = '0;
		r.kind = KIND_FIN;
		lz = '0;
		if (e == 8'hFF) begin
			r.kind = (m != '0) ? KIND_NAN : KIND_INF;
		end else if (e == 8'h00) begin
			if (m == '0) begin
				r.kind = KIND_ZERO;
			end else begin
				for (int i = 0; i < 23; i++) begin
					if (m[i]) lz = 5'(22 - i);
				end
				r.mant = {1'b0, m} << (lz + 5'd1);
				r.q = Q_DENORM - Q_W'(lz) - 10'sd1;
			end
		end else begin
			r.mant = {1'b1, m};
			r.q = $signed({2'b00, e}) - 10'sd150;
		end
		return r;
	endfunction

	function automatic logic [31:0] fpau_pack(input logic sg, input logic [23:0] mant,
			input logic signed [12:0] q);
		logic signed [13:0] e;
		e = 14'(q) + 14'sd150;
		if (e >= 14'sd255) return {sg, INF_BITS[30:0]};
		if (e <= 14'sd0) return {sg, 31'd0};
		return {sg, e[7:0], mant[22:0]};
	endfunction

	// round m * 2^q to 24 bits, nearest even; m < 2^63
	function automatic logic [31:0] fpau_round(input logic sg, input logic [63:0] m,
			input logic signed [RQ_W-1:0] q);
		logic [6:0] bl;
		logic [63:0] mn;
		logic [24:0] r;
		logic up;
		logic signed [12:0] qn;
		bl = '0;
		if (m == '0) return 32'd0;
		for (int i = 0; i < 64; i++) begin
			if (m[i]) bl = 7'(i + 1);
		end
		mn = m << (7'd64 - bl);
		up = mn[39] && ((|mn[38:0]) || mn[40]);
		r = {1'b0, mn[63:40]} + {24'd0, up};
		qn = 13'(q) + $signed({6'b0, bl}) - 13'sd24;
		if (r[24]) begin
			return fpau_pack(sg, r[24:1], qn + 13'sd1);
		end
		return fpau_pack(sg, r[23:0], qn);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/fp32_add_mul_cmp_unit.sv =====
`default_nettype none
// m_tvalid rises once a transaction has passed the input register and the result register;
// a stall on m_tready can hold it in either register.
// Throughput: one transaction per cycle while m_tready does not stall the output; set
// by the single compute pass between the two registers.
// Reset: arst_n clears both valid bits asynchronously; the data registers are not reset.
// ---------------------------------------------------------------------------
// fp32_add_mul_cmp_unit
// binary32 add, multiply, greater-than compare and negate stream unit.
// ---------------------------------------------------------------------------
module fp32_add_mul_cmp_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // operand_a[31:0], operand_b[63:32]
	input  wire logic [1:0]  s_tuser,  // operation[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata   // result_bits[31:0]
);
	import fpau_pkg::*;

	logic        vld_s1, vld_s2;
	logic [1:0]  op_s1;
	logic [31:0] a_s1, b_s1, res_s2;
	logic [31:0] add_res, mul_res, res;
	logic        gt;
	logic        adv;

	fpau_add u_add (.a(a_s1), .b(b_s1), .res(add_res));
	fpau_mul u_mul (.a(a_s1), .b(b_s1), .res(mul_res));
	fpau_cmp u_cmp (.a(a_s1), .b(b_s1), .gt(gt));

	always_comb begin
		unique case (op_s1)
			OP_ADD:  res = add_res;
			OP_MUL:  res = mul_res;
			OP_CMP:  res = {31'd0, gt};
			OP_NEG:  res = a_s1 ^ SIGN_BIT;
			default: res = a_s1;
		endcase
	end

	assign adv      = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv;
	assign m_tvalid = vld_s2;
	assign m_tdata  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv) vld_s2 <= vld_s1;
			if (s_tready) vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1 <= s_tuser;
			a_s1  <= s_tdata[31:0];
			b_s1  <= s_tdata[63:32];
		end
		if (adv && vld_s1) res_s2 <= res;
	end

endmodule
`default_nettype wire

// ===== rtl/fpau_add.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fpau_add
// binary32 adder: align, add/subtract with sticky, single rounding.
// ---------------------------------------------------------------------------
module fpau_add (
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] res
);
	import fpau_pkg::*;

	fpau_val_t ua, ub, h, l;
	logic signed [10:0] d;
	logic [63:0] x, yfull, ys, y, msum;
	logic sg;

	always_comb begin
		ua = fpau_unpack(a);
		ub = fpau_unpack(b);
		if (ua.q >= ub.q) begin
			h = ua;
			l = ub;
		end else begin
			h = ub;
			l = ua;
		end
		d = 11'(h.q) - 11'(l.q);
		x = {8'd0, h.mant, 32'd0};
		yfull = {8'd0, l.mant, 32'd0};
		ys = yfull >> d[5:0];
		if (d >= 11'sd56) y = 64'd1;
		else y = ys | {63'd0, ((ys << d[5:0]) != yfull)};
		if (h.sg == l.sg) begin
			msum = x + y;
			sg = h.sg;
		end else if (x > y) begin
			msum = x - y;
			sg = h.sg;
		end else begin
			msum = y - x;
			sg = l.sg;
		end

		if (ua.kind == KIND_NAN || ub.kind == KIND_NAN) begin
			res = QNAN_BITS;
		end else if (ua.kind == KIND_INF || ub.kind == KIND_INF) begin
			if (ua.kind == KIND_INF && ub.kind == KIND_INF && ua.sg != ub.sg)
				res = QNAN_BITS;
			else
				res = {(ua.kind == KIND_INF) ? ua.sg : ub.sg, INF_BITS[30:0]};
		end else if (ua.kind == KIND_ZERO && ub.kind == KIND_ZERO) begin
			res = {ua.sg & ub.sg, 31'd0};
		end else if (ua.kind == KIND_ZERO) begin
			res = fpau_pack(ub.sg, ub.mant, 13'(ub.q));
		end else if (ub.kind == KIND_ZERO) begin
			res = fpau_pack(ua.sg, ua.mant, 13'(ua.q));
		end else if (h.sg != l.sg && x == y) begin
			res = 32'd0;
		end else begin
			res = fpau_round(sg, msum, 12'(h.q) - 12'sd32);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/fpau_mul.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fpau_mul
// binary32 multiplier: 24x24 significand product, single rounding.
// ---------------------------------------------------------------------------
module fpau_mul (
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] res
);
	import fpau_pkg::*;

	fpau_val_t ua, ub;
	logic [47:0] prod;
	logic sg;

	always_comb begin
		ua = fpau_unpack(a);
		ub = fpau_unpack(b);
		sg = ua.sg ^ ub.sg;
		prod = ua.mant * ub.mant;
		if (ua.kind == KIND_NAN || ub.kind == KIND_NAN) begin
			res = QNAN_BITS;
		end else if (ua.kind == KIND_INF || ub.kind == KIND_INF) begin
			if (ua.kind == KIND_ZERO || ub.kind == KIND_ZERO) res = QNAN_BITS;
			else res = {sg, INF_BITS[30:0]};
		end else if (ua.kind == KIND_ZERO || ub.kind == KIND_ZERO) begin
			res = {sg, 31'd0};
		end else begin
			res = fpau_round(sg, {16'd0, prod}, 12'(ua.q) + 12'(ub.q));
		end
	end

endmodule
`default_nettype wire

// ===== rtl/fpau_cmp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fpau_cmp
// binary32 strict greater-than; false on NaN, signed zeros equal.
// ---------------------------------------------------------------------------
module fpau_cmp (
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic             gt
);
	import fpau_pkg::*;

	fpau_val_t ua, ub;
	logic a_big, same;

	always_comb begin
		ua = fpau_unpack(a);
		ub = fpau_unpack(b);
		a_big = (ua.q > ub.q) || (ua.q == ub.q && ua.mant > ub.mant);
		same = (ua.q == ub.q) && (ua.mant == ub.mant);
		if (ua.kind == KIND_NAN || ub.kind == KIND_NAN) begin
			gt = 1'b0;
		end else if (ua.kind == KIND_INF && ub.kind == KIND_INF) begin
			gt = !ua.sg && ub.sg;
		end else if (ua.kind == KIND_INF) begin
			gt = !ua.sg;
		end else if (ub.kind == KIND_INF) begin
			gt = ub.sg;
		end else if (ua.kind == KIND_ZERO && ub.kind == KIND_ZERO) begin
			gt = 1'b0;
		end else if (ua.kind == KIND_ZERO) begin
			gt = ub.sg;
		end else if (ub.kind == KIND_ZERO) begin
			gt = !ua.sg;
		end else if (ua.sg != ub.sg) begin
			gt = !ua.sg;
		end else if (!ua.sg) begin
			gt = a_big;
		end else begin
			gt = !a_big && !same;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/fpau_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fpau_checker
// Port-level checks for the binary32 unit, bound to the top level.
// ---------------------------------------------------------------------------
module fpau_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [63:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);
	import fpau_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without input transaction");

	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == OP_NEG) ##1 (!m_tvalid || m_tready)
		|=> m_tvalid && m_tdata == ($past(s_tdata[31:0], 2) ^ SIGN_BIT))
		else $error("negate result wrong");

	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == OP_CMP) ##1 (!m_tvalid || m_tready)
		|=> m_tvalid && m_tdata[31:1] == 31'd0)
		else $error("compare result not 0 or 1");

endmodule

bind fp32_add_mul_cmp_unit fpau_checker u_fpau_checker (.*);
`default_nettype wire

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Streams binary32 add, multiply, compare and negate transactions through
// the unit, predicts each result with an independent model and checks the
// output stream in order under random source and sink stalls.
// ---------------------------------------------------------------------------
module testbench;
	import fpau_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	logic [31:0] expected_q[$];
	int          errors;
	int          cycles;
	int          sink_hold;
	logic        sink_random;

	fp32_add_mul_cmp_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// decoded operand: value = man * 2^ex
	typedef struct {
		int          cls;
		bit          sg;
		longint      man;
		int          ex;
	} num_t;

	localparam int C_ZERO = 0;
	localparam int C_FIN  = 1;
	localparam int C_INF  = 2;
	localparam int C_NAN  = 3;

	function automatic num_t decode(logic [31:0] u);
		num_t n;
		n.sg = u[31];
		n.man = 0;
		n.ex = 0;
		if (u[30:23] == 8'hFF) begin
			n.cls = (u[22:0] != 0) ? C_NAN : C_INF;
		end else if (u[30:23] == 0) begin
			if (u[22:0] == 0) begin
				n.cls = C_ZERO;
			end else begin
				n.cls = C_FIN;
				n.man = u[22:0];
				n.ex = -149;
				while (n.man < 64'h80_0000) begin
					n.man = n.man << 1;
					n.ex--;
				end
			end
		end else begin
			n.cls = C_FIN;
			n.man = {1'b1, u[22:0]};
			n.ex = int'(u[30:23]) - 150;
		end
		return n;
	endfunction

	function automatic logic [31:0] encode(bit sg, longint man, int ex);
		int e;
		e = ex + 150;
		if (e >= 255) return {sg, 31'h7F80_0000};
		if (e <= 0) return {sg, 31'd0};
		return {sg, e[7:0], man[22:0]};
	endfunction

	function automatic logic [31:0] round_nearest(bit sg, logic [63:0] m, int ex);
		int nb;
		int sh;
		logic [63:0] rem;
		logic [63:0] half;
		if (m == 0) return 32'd0;
		nb = 0;
		for (int i = 0; i < 64; i++) if (m[i]) nb = i + 1;
		if (nb > 24) begin
			sh = nb - 24;
			rem = m & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			m = m >> sh;
			ex += sh;
			if (rem > half || (rem == half && m[0])) begin
				m++;
				if (m == 64'h100_0000) begin
					m = m >> 1;
					ex++;
				end
			end
		end else begin
			m = m << (24 - nb);
			ex -= 24 - nb;
		end
		return encode(sg, m, ex);
	endfunction

	function automatic logic [31:0] predict_mul(logic [31:0] a, logic [31:0] b);
		num_t x, y;
		bit sg;
		x = decode(a);
		y = decode(b);
		sg = x.sg ^ y.sg;
		if (x.cls == C_NAN || y.cls == C_NAN) return QNAN_BITS;
		if (x.cls == C_INF || y.cls == C_INF) begin
			if (x.cls == C_ZERO || y.cls == C_ZERO) return QNAN_BITS;
			return {sg, INF_BITS[30:0]};
		end
		if (x.cls == C_ZERO || y.cls == C_ZERO) return {sg, 31'd0};
		return round_nearest(sg, 64'(x.man) * 64'(y.man), x.ex + y.ex);
	endfunction

	function automatic logic [31:0] predict_add(logic [31:0] a, logic [31:0] b);
		num_t x, y, hi, lo;
		logic [63:0] big, sml, sum;
		int d;
		bit sg;
		x = decode(a);
		y = decode(b);
		if (x.cls == C_NAN || y.cls == C_NAN) return QNAN_BITS;
		if (x.cls == C_INF || y.cls == C_INF) begin
			if (x.cls == C_INF && y.cls == C_INF && x.sg != y.sg) return QNAN_BITS;
			return {(x.cls == C_INF) ? x.sg : y.sg, INF_BITS[30:0]};
		end
		if (x.cls == C_ZERO && y.cls == C_ZERO) return {x.sg & y.sg, 31'd0};
		if (x.cls == C_ZERO) return encode(y.sg, y.man, y.ex);
		if (y.cls == C_ZERO) return encode(x.sg, x.man, x.ex);
		if (x.ex >= y.ex) begin
			hi = x;
			lo = y;
		end else begin
			hi = y;
			lo = x;
		end
		d = hi.ex - lo.ex;
		big = 64'(hi.man) << 32;
		if (d >= 56) begin
			sml = 64'd1;
		end else begin
			sml = 64'(lo.man) << 32;
			if (d > 0) begin
				sml = (sml >> d) | 64'((sml & ((64'd1 << d) - 1)) != 0);
			end
		end
		if (hi.sg == lo.sg) begin
			sum = big + sml;
			sg = hi.sg;
		end else if (big == sml) begin
			return 32'd0;
		end else if (big > sml) begin
			sum = big - sml;
			sg = hi.sg;
		end else begin
			sum = sml - big;
			sg = lo.sg;
		end
		return round_nearest(sg, sum, hi.ex - 32);
	endfunction

	function automatic logic [31:0] predict_gt(logic [31:0] a, logic [31:0] b);
		num_t x, y;
		bit larger, equal;
		x = decode(a);
		y = decode(b);
		if (x.cls == C_NAN || y.cls == C_NAN) return 32'd0;
		if (x.cls == C_INF && y.cls == C_INF) return 32'(!x.sg && y.sg);
		if (x.cls == C_INF) return 32'(!x.sg);
		if (y.cls == C_INF) return 32'(y.sg);
		if (x.cls == C_ZERO && y.cls == C_ZERO) return 32'd0;
		if (x.cls == C_ZERO) return 32'(y.sg);
		if (y.cls == C_ZERO) return 32'(!x.sg);
		if (x.sg != y.sg) return 32'(!x.sg);
		larger = (x.ex > y.ex) || (x.ex == y.ex && x.man > y.man);
		equal = (x.ex == y.ex && x.man == y.man);
		if (!x.sg) return 32'(larger);
		return 32'(!larger && !equal);
	endfunction

	function automatic logic [31:0] predict_result(fpau_op_t op, logic [31:0] a,
			logic [31:0] b);
		case (op)
			OP_ADD: return predict_add(a, b);
			OP_MUL: return predict_mul(a, b);
			OP_CMP: return predict_gt(a, b);
			default: return a ^ SIGN_BIT;
		endcase
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	// s_tvalid stays high after a transaction; it drops only for a gap or in wait_drain
	task automatic send_op(fpau_op_t op, logic [31:0] a, logic [31:0] b, bit gaps = 1);
		int gap;
		gap = gaps ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {b, a};
		expected_q.push_back(predict_result(op, a, b));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] random_operand();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[30:23] = 8'h00;
			1: v[30:23] = 8'hFF;
			2: v[30:0] = 31'd0;
			3: v[30:23] = 8'($urandom_range(1, 6));
			4: v[30:23] = 8'($urandom_range(249, 254));
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_special_values();
		logic [31:0] vals[12];
		vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
			32'h7F7F_FFFF, 32'h0080_0000, 32'h3F80_0000, 32'hBF80_0000};
		for (int i = 0; i < 12; i++) begin
			send_op(fpau_op_t'(i % 4), vals[i], vals[(i * 5 + 3) % 12]);
		end
		send_op(OP_ADD, 32'h7F80_0000, 32'hFF80_0000);
		send_op(OP_ADD, 32'h8000_0000, 32'h8000_0000);
		send_op(OP_ADD, 32'h3F80_0000, 32'hBF80_0000);
		send_op(OP_ADD, 32'h0000_0000, 32'h0000_0005);
		send_op(OP_MUL, 32'h7F80_0000, 32'h8000_0000);
		send_op(OP_MUL, 32'h7F7F_FFFF, 32'h4000_0000);
		send_op(OP_MUL, 32'h0080_0000, 32'h3F00_0000);
		send_op(OP_CMP, 32'h0000_0000, 32'h8000_0000);
		send_op(OP_CMP, 32'h7FC0_0000, 32'h0000_0000);
		send_op(OP_NEG, 32'h7FC0_0001, 32'hFFFF_FFFF);
		send_op(OP_ADD, 32'h3F80_0000, 32'h3380_0000);
		send_op(OP_ADD, 32'h3F80_0001, 32'h3380_0000);
		wait_drain();
	endtask

	task automatic test_random_ops(int count);
		for (int i = 0; i < count; i++) begin
			send_op(fpau_op_t'($urandom_range(0, 3)), random_operand(), random_operand());
		end
	endtask

	task automatic test_backpressure();
		sink_random = 1'b0;
		sink_hold = 300;
		for (int i = 0; i < 40; i++) begin
			send_op(fpau_op_t'($urandom_range(0, 3)), $urandom, $urandom, 0);
		end
		sink_random = 1'b1;
		wait_drain();
	endtask

	task automatic test_full_rate();
		sink_random = 1'b0;
		for (int i = 0; i < 100; i++) begin
			send_op(fpau_op_t'($urandom_range(0, 3)), random_operand(), random_operand(), 0);
		end
		sink_random = 1'b1;
		wait_drain();
	endtask

	always @(posedge clk) begin
		int stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall = 0;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else if (!sink_random) begin
			m_tready <= 1'b1;
		end else if (stall > 0) begin
			stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (m_tvalid && m_tready && $urandom_range(0, 3) == 0) stall = $urandom_range(0, 16);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				report("unexpected transaction", m_tdata, 32'd0);
			end else begin
				if (m_tdata !== expected_q[0]) report("result_bits", m_tdata, expected_q[0]);
				void'(expected_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		sink_hold = 0;
		sink_random = 1'b1;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_ADD;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_values();
		test_random_ops(250);
		wait_drain();
		test_backpressure();
		test_full_rate();
		test_random_ops(250);
		wait_drain();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
